// ===== design/btad_pkg.sv =====
// Package for the binary to ASCII decimal unit.
// Holds the beat types, the power-of-ten table and the character constants.
// No dependencies.
package btad_pkg;

    localparam int VALUE_W            = 32;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;
    localparam int VALUE_DIGITS       = 10;
    localparam int POS_W              = $clog2(VALUE_DIGITS);
    localparam int CAND_W             = 34;
    localparam int MAX_DIGITS_DEFAULT = 10;
    localparam int MAX_DIGITS_LIMIT   = 20;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

    localparam logic [CAND_W-1:0] POW10 [VALUE_DIGITS] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_out_item;

endpackage

// ===== design/btad_digit_unit.sv =====
// Shared digit unit: finds one decimal digit of the remainder at a given
// position by comparing against all nine multiples of that power of ten.
// Depends on btad_pkg.
module btad_digit_unit (
    input  logic [btad_pkg::VALUE_W-1:0] i_rem,
    input  logic [btad_pkg::POS_W-1:0]   i_pos,
    output logic [btad_pkg::DIGIT_W-1:0] o_digit,
    output logic [btad_pkg::VALUE_W-1:0] o_rem
);
    import btad_pkg::*;

    logic [CAND_W-1:0] pow;
    logic [CAND_W-1:0] rem_ext;
    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] sel;
    logic [CAND_W-1:0] diff;

    always_comb begin
        pow     = POW10[i_pos];
        rem_ext = CAND_W'(i_rem);
        o_digit = '0;
        sel     = '0;
        // The multiples rise with d, so the last one that fits gives the digit.
        for (int d = 1; d < 10; d++) begin
            cand = pow * CAND_W'(d);
            if (rem_ext >= cand) begin
                o_digit = DIGIT_W'(d);
                sel     = cand;
            end
        end
        diff  = rem_ext - sel;
        o_rem = diff[VALUE_W-1:0];
    end

endmodule

// ===== design/btad_out_stage.sv =====
// Output holding register for result beats, so the sequencer can run
// while a finished character waits downstream.
// Depends on btad_pkg.
module btad_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  btad_pkg::t_out_item i_data,
    output logic                o_free,
    output logic                o_valid,
    output btad_pkg::t_out_item o_data,
    input  logic                i_stall
);
    import btad_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        if (i_push) begin
            n_valid = 1'b1;
        end else if (r_valid && i_stall) begin
            n_valid = 1'b1;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_push) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== design/binary_to_ascii_decimal_unit.sv =====
// Top level of the binary to ASCII decimal unit: digit sequencer.
// Depends on btad_pkg, btad_digit_unit and btad_out_stage.
//
//   Channel | Direction | Handshake             | Beat
//   in      | input     | i_in_valid/o_in_stall  | t_in_item (kind, value)
//   out     | output    | o_out_valid/i_out_stall| t_out_item (char_code, last)
//
// A plain integer passes through ten digit positions in S_DIGIT, one digit
// position per cycle through the shared digit unit while no output stall
// holds it, most significant first. The hundredths format adds an S_DOT step
// for the decimal point between value positions 2 and 1. The last position
// returns the sequencer to S_IDLE, where the next beat is accepted. The input
// is stalled while a number is being converted; the next item is accepted as
// soon as the sequencer is idle, even while the last character still waits in
// the output register. Output stalls hold the sequencer when it has a character
// to hand over and the output register is full. Reset empties both sides.
module binary_to_ascii_decimal_unit #(
    parameter int MAX_DIGITS = btad_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  btad_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output btad_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import btad_pkg::*;

    localparam int NC = (MAX_DIGITS > MAX_DIGITS_LIMIT) ? MAX_DIGITS_LIMIT :
                        ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int CMP_W = 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGIT,
        S_DOT
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] n_rem;
    logic               r_kind;
    logic               n_kind;
    logic               r_started;
    logic               n_started;

    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem_next;
    logic [CMP_W-1:0]   pos_ext;
    logic               in_window;
    logic               must_print;
    logic               emit;
    logic               push;
    logic               out_free;
    t_out_item          push_data;

    btad_digit_unit u_digit (
        .i_rem   (r_rem),
        .i_pos   (r_pos),
        .o_digit (digit),
        .o_rem   (rem_next)
    );

    btad_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        pos_ext = CMP_W'(r_pos);
        // In the hundredths format, value position p is integer position p-2,
        // and the two lowest positions are the fraction.
        if (r_kind) begin
            if (r_pos >= POS_W'(2)) begin
                in_window = (pos_ext < CMP_W'(NC + 2));
            end else begin
                in_window = 1'b1;
            end
            must_print = (r_pos <= POS_W'(2));
        end else begin
            in_window  = (pos_ext < CMP_W'(NC));
            must_print = (r_pos == '0);
        end
        emit = in_window && (r_started || (digit != '0) || must_print);

        push_data.char_code = ASCII_ZERO + CHAR_W'(digit);
        push_data.last      = (r_pos == '0);
        push                = 1'b0;

        n_state   = r_state;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_kind    = r_kind;
        n_started = r_started;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state   = S_DIGIT;
                    n_pos     = POS_W'(VALUE_DIGITS - 1);
                    n_rem     = i_in_data.value;
                    n_kind    = i_in_data.kind;
                    n_started = 1'b0;
                end
            end
            S_DIGIT: begin
                if (!emit || out_free) begin
                    push      = emit;
                    n_rem     = rem_next;
                    n_started = r_started || emit;
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else if (r_kind && (r_pos == POS_W'(2))) begin
                        n_state = S_DOT;
                        n_pos   = r_pos - POS_W'(1);
                    end else begin
                        n_pos   = r_pos - POS_W'(1);
                    end
                end
            end
            S_DOT: begin
                push_data.char_code = ASCII_DOT;
                push_data.last      = 1'b0;
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_DIGIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
        r_pos  <= n_pos;
        r_rem  <= n_rem;
        r_kind <= n_kind;
    end

    // The decimal point belongs to the hundredths format only.
    a_dot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOT) |-> r_kind)
        else $error("decimal point step outside hundredths format");

    // Handing over the final character ends the number.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_data.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final character");

    // The remainder always fits below ten units of the current position.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |->
        ((r_pos < POS_W'(VALUE_DIGITS)) &&
         (CAND_W'(r_rem) < POW10[r_pos] * CAND_W'(10))))
        else $error("remainder out of range for digit position");

    // A pending character is never lost under an output stall.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && o_out_valid) |-> !i_out_stall)
        else $error("character pushed over a stalled output beat");

endmodule
